/* src/rrts_pkg.sv */
// rrts_pkg: shared types and constants of the round-robin task scheduler
// holds slot, request and status codes, controller op and state codes and status struct
// no dependencies
package rrts_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = 4;
  localparam int SIG_W  = 32;
  localparam int ID_W   = 16;
  localparam int WPID_W = ID_W + 1;
  localparam logic [WPID_W-1:0] WAIT_NONE = '1;

  localparam int IN_DATA_W  = 104;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 56;

  // configuration register indexes
  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_TERM   = 2'd1;
  localparam logic [1:0] CFG_INTR   = 2'd2;

  typedef enum logic [1:0] {
    SS_UNUSED = 2'd0,
    SS_RUN    = 2'd1,
    SS_WAIT   = 2'd2,
    SS_ZOMBIE = 2'd3
  } slot_state_e;

  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_CREATE = 3'd1,
    REQ_EXIT   = 3'd2,
    REQ_WAIT   = 3'd3,
    REQ_SIGNAL = 3'd4,
    REQ_MASK   = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    RS_DONE     = 3'd0,
    RS_IGNORED  = 3'd1,
    RS_FULL     = 3'd2,
    RS_NOTFOUND = 3'd3,
    RS_BLOCKED  = 3'd4
  } res_status_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DISPATCH, OP_WSTART, OP_WALK, OP_PICK, OP_WAKE,
    OP_CREATE, OP_INSERT, OP_EXIT, OP_FIND, OP_REMOVE, OP_BLOCK,
    OP_SIGNAL, OP_MASK, OP_OUT
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_WSTART, S_WALK, S_PICK, S_WAKE, S_CREATE,
    S_INSERT, S_EXIT, S_FIND, S_REMOVE, S_BLOCK, S_SIGNAL, S_MASK, S_OUT
  } fsm_state_e;

  typedef struct packed {
    logic [2:0] req;
    logic       tick_go;
    logic       cur_valid;
    logic       head_valid;
    logic       last;
    logic       walk_done;
    logic       walk_found;
    logic       kill;
    logic       create_hit;
    logic       find_hit;
    logic       find_zombie;
    logic       need_remove;
    logic       remove_done;
    logic       out_free;
  } dp_stat_t;

endpackage

/* src/rrts_ctrl.sv */
// rrts_ctrl: sequencing state machine of the task scheduler
// issues one datapath op per cycle from datapath status, none while awaiting a request or result room; uses rrts_pkg
module rrts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rrts_pkg::dp_stat_t stat_i,
  output rrts_pkg::dp_op_e   op_o
);
  import rrts_pkg::*;

  fsm_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (stat_i.req)
          REQ_TICK:   state_d = stat_i.tick_go ? S_WSTART : S_OUT;
          REQ_CREATE: state_d = S_CREATE;
          REQ_EXIT:   state_d = stat_i.cur_valid ? S_EXIT : S_OUT;
          REQ_WAIT:   state_d = S_FIND;
          REQ_SIGNAL: state_d = S_SIGNAL;
          REQ_MASK:   state_d = stat_i.cur_valid ? S_MASK : S_OUT;
          default:    state_d = S_OUT;
        endcase
      end
      S_WSTART: state_d = S_WALK;
      S_WALK: begin
        if (stat_i.walk_done) state_d = stat_i.walk_found ? S_PICK : S_OUT;
      end
      S_PICK: state_d = stat_i.kill ? S_WAKE : S_OUT;
      S_WAKE: begin
        if (stat_i.last) state_d = S_OUT;
      end
      S_CREATE: begin
        if (stat_i.create_hit) state_d = stat_i.head_valid ? S_INSERT : S_OUT;
        else if (stat_i.last) state_d = S_OUT;
      end
      S_INSERT: state_d = S_OUT;
      S_EXIT:   state_d = S_WAKE;
      S_FIND: begin
        if (stat_i.find_hit) begin
          if (stat_i.find_zombie) state_d = stat_i.need_remove ? S_REMOVE : S_OUT;
          else state_d = stat_i.cur_valid ? S_BLOCK : S_OUT;
        end else if (stat_i.last) begin
          state_d = S_OUT;
        end
      end
      S_REMOVE: begin
        if (stat_i.remove_done) state_d = S_OUT;
      end
      S_BLOCK: state_d = S_OUT;
      S_SIGNAL: begin
        if (stat_i.last) state_d = S_OUT;
      end
      S_MASK: state_d = S_OUT;
      S_OUT: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    op_o       = OP_NONE;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) op_o = OP_LOAD;
      end
      S_DISPATCH: op_o = OP_DISPATCH;
      S_WSTART:   op_o = OP_WSTART;
      S_WALK:     op_o = OP_WALK;
      S_PICK:     op_o = OP_PICK;
      S_WAKE:     op_o = OP_WAKE;
      S_CREATE:   op_o = OP_CREATE;
      S_INSERT:   op_o = OP_INSERT;
      S_EXIT:     op_o = OP_EXIT;
      S_FIND:     op_o = OP_FIND;
      S_REMOVE:   op_o = OP_REMOVE;
      S_BLOCK:    op_o = OP_BLOCK;
      S_SIGNAL:   op_o = OP_SIGNAL;
      S_MASK:     op_o = OP_MASK;
      S_OUT: begin
        if (stat_i.out_free) op_o = OP_OUT;
      end
      default: op_o = OP_NONE;
    endcase
  end

endmodule

/* src/rrts_datapath.sv */
// rrts_datapath: task table, run ring, request and result registers
// all table reads go through one slot index; uses rrts_pkg
module rrts_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rrts_pkg::dp_op_e                    op_i,
  input  logic                                cfg_enable_i,
  input  logic [4:0]                          cfg_term_i,
  input  logic [4:0]                          cfg_intr_i,
  input  logic [rrts_pkg::IN_USER_W-1:0]      in_user_i,
  input  logic [rrts_pkg::IN_DATA_W-1:0]      in_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [rrts_pkg::OUT_DATA_W-1:0]     out_data_o,
  output rrts_pkg::dp_stat_t                  stat_o
);
  import rrts_pkg::*;

  // task table
  slot_state_e             st_q    [SLOTS];
  logic [ID_W-1:0]         id_q    [SLOTS];
  logic                    idle_q  [SLOTS];
  logic [ID_W-1:0]         grp_q   [SLOTS];
  logic [WPID_W-1:0]       wpid_q  [SLOTS];
  logic [SIG_W-1:0]        pend_q  [SLOTS];
  logic [SIG_W-1:0]        blk_q   [SLOTS];
  logic [31:0]             exit_q  [SLOTS];
  logic [SLOT_W-1:0]       next_q  [SLOTS];

  // control state
  logic              head_valid_q, cur_valid_q;
  logic [SLOT_W-1:0] head_q, cur_q, idx_q;
  logic [ID_W-1:0]   id_cnt_q;
  logic              out_valid_q;

  // request fields and work registers
  logic [2:0]        req_q;
  logic              r_idle_q;
  logic [ID_W-1:0]   r_grp_q, r_pid_q, wake_pid_q, cur_id_q;
  logic [31:0]       r_exv_q, r_mask_q;
  logic [4:0]        r_sig_q;
  logic [SLOT_W-1:0] start_q, cnt_q, idle_slot_q, ch_q, ch_next_q, new_q;
  logic              have_idle_q;
  logic [2:0]        res_status_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic [ID_W-1:0]   res_tid_q;
  logic [31:0]       res_code_q;
  logic              res_killed_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  // reads at the slot index
  slot_state_e       rd_st;
  logic [ID_W-1:0]   rd_id, rd_grp;
  logic              rd_idle;
  logic [WPID_W-1:0] rd_wpid;
  logic [SIG_W-1:0]  rd_pend, rd_blk;
  logic [31:0]       rd_exit;
  logic [SLOT_W-1:0] rd_next;

  assign rd_st   = st_q[idx_q];
  assign rd_id   = id_q[idx_q];
  assign rd_grp  = grp_q[idx_q];
  assign rd_idle = idle_q[idx_q];
  assign rd_wpid = wpid_q[idx_q];
  assign rd_pend = pend_q[idx_q];
  assign rd_blk  = blk_q[idx_q];
  assign rd_exit = exit_q[idx_q];
  assign rd_next = next_q[idx_q];

  logic rd_run, last, walk_hit, walk_end, walk_done, walk_found;
  logic [SLOT_W-1:0] walk_sel;
  logic find_hit, remove_direct, rm_match, rm_done, out_free;
  logic [SIG_W-1:0] cand, low, clr, new_pend;
  logic kill;

  assign rd_run     = (rd_st == SS_RUN);
  assign last       = (idx_q == SLOT_W'(SLOTS - 1));
  assign walk_hit   = rd_run && !rd_idle;
  assign walk_end   = (idx_q == start_q) || (cnt_q == SLOT_W'(SLOTS - 1));
  assign walk_done  = walk_hit || walk_end;
  assign walk_found = walk_hit || (walk_end && (rd_run || have_idle_q));
  assign walk_sel   = rd_run ? idx_q : idle_slot_q;

  // signal delivery: lowest unblocked pending bit above bit 0; it and the bits below it, bar bit 0, are dropped
  assign cand     = rd_pend & ~rd_blk & ~SIG_W'(1);
  assign low      = cand & (~cand + SIG_W'(1));
  assign clr      = (|cand) ? ((low | (low - SIG_W'(1))) & ~SIG_W'(1)) : ~SIG_W'(1);
  assign new_pend = rd_pend & ~clr;
  assign kill     = low[cfg_term_i] | low[cfg_intr_i];

  assign find_hit      = (rd_st != SS_UNUSED) && (rd_id == r_pid_q);
  assign remove_direct = (head_q == idx_q) && (rd_next == idx_q);
  assign rm_match      = (rd_next == ch_q);
  assign rm_done       = rm_match || (rd_next == head_q) || (cnt_q == SLOT_W'(SLOTS - 1));
  assign out_free      = !out_valid_q || out_ready_i;

  // status to the controller
  always_comb begin
    stat_o.req         = req_q;
    stat_o.tick_go     = cfg_enable_i && head_valid_q;
    stat_o.cur_valid   = cur_valid_q;
    stat_o.head_valid  = head_valid_q;
    stat_o.last        = last;
    stat_o.walk_done   = walk_done;
    stat_o.walk_found  = walk_found;
    stat_o.kill        = kill;
    stat_o.create_hit  = (rd_st == SS_UNUSED);
    stat_o.find_hit    = find_hit;
    stat_o.find_zombie = (rd_st == SS_ZOMBIE);
    stat_o.need_remove = head_valid_q && !remove_direct;
    stat_o.remove_done = rm_done;
    stat_o.out_free    = out_free;
  end

  // control registers: slot states, ring head, current task, index, id counter, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) st_q[i] <= SS_UNUSED;
      head_valid_q <= 1'b0;
      head_q       <= '0;
      cur_valid_q  <= 1'b0;
      cur_q        <= '0;
      idx_q        <= '0;
      id_cnt_q     <= ID_W'(1);
      out_valid_q  <= 1'b0;
    end else begin
      // result valid: set when a beat is loaded, cleared when taken
      if (op_i == OP_OUT) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (op_i)
        OP_DISPATCH: begin
          case (req_q)
            REQ_TICK:              idx_q <= cur_valid_q ? cur_q : head_q;
            REQ_EXIT, REQ_MASK:    idx_q <= cur_q;
            default:               idx_q <= '0;
          endcase
        end
        OP_WSTART: idx_q <= rd_next;
        OP_WALK: begin
          if (!walk_done) idx_q <= rd_next;
          else if (walk_found) idx_q <= walk_sel;
        end
        OP_PICK: begin
          cur_q       <= idx_q;
          cur_valid_q <= 1'b1;
          if (kill) st_q[idx_q] <= SS_ZOMBIE;
          idx_q <= '0;
        end
        OP_WAKE: begin
          if (rd_st == SS_WAIT && rd_wpid == {1'b0, wake_pid_q}) st_q[idx_q] <= SS_RUN;
          idx_q <= idx_q + SLOT_W'(1);
        end
        OP_CREATE: begin
          if (rd_st == SS_UNUSED) begin
            st_q[idx_q] <= SS_RUN;
            id_cnt_q    <= id_cnt_q + ID_W'(1);
            if (!cur_valid_q) begin
              cur_valid_q <= 1'b1;
              cur_q       <= idx_q;
            end
            if (head_valid_q) begin
              idx_q <= head_q;
            end else begin
              head_valid_q <= 1'b1;
              head_q       <= idx_q;
            end
          end else begin
            idx_q <= idx_q + SLOT_W'(1);
          end
        end
        OP_EXIT: begin
          st_q[idx_q] <= SS_ZOMBIE;
          idx_q       <= '0;
        end
        OP_FIND: begin
          if (find_hit) begin
            if (rd_st == SS_ZOMBIE) begin
              st_q[idx_q] <= SS_UNUSED;
              if (cur_valid_q && cur_q == idx_q) cur_valid_q <= 1'b0;
              if (head_valid_q) begin
                if (remove_direct) head_valid_q <= 1'b0;
                else idx_q <= head_q;
              end
            end else if (cur_valid_q) begin
              idx_q <= cur_q;
            end
          end else begin
            idx_q <= idx_q + SLOT_W'(1);
          end
        end
        OP_REMOVE: begin
          if (rm_match) begin
            if (head_q == ch_q) head_q <= ch_next_q;
          end else if (!rm_done) begin
            idx_q <= rd_next;
          end
        end
        OP_BLOCK: begin
          if (rd_run) st_q[idx_q] <= SS_WAIT;
        end
        OP_SIGNAL: idx_q <= idx_q + SLOT_W'(1);
        default: ;
      endcase
    end
  end

  // payload registers: slot fields, ring links, request and result fields
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        req_q        <= in_user_i;
        r_idle_q     <= in_data_i[0];
        r_grp_q      <= in_data_i[16:1];
        r_exv_q      <= in_data_i[48:17];
        r_pid_q      <= in_data_i[64:49];
        r_sig_q      <= in_data_i[69:65];
        r_mask_q     <= in_data_i[101:70];
        res_status_q <= RS_IGNORED;
        res_slot_q   <= '0;
        res_tid_q    <= '0;
        res_code_q   <= '0;
        res_killed_q <= 1'b0;
      end
      OP_DISPATCH: begin
        if (req_q == REQ_SIGNAL) res_status_q <= RS_DONE;
      end
      OP_WSTART: begin
        start_q     <= idx_q;
        cnt_q       <= '0;
        have_idle_q <= 1'b0;
      end
      OP_WALK: begin
        if (!walk_done) begin
          cnt_q <= cnt_q + SLOT_W'(1);
          if (rd_run && rd_idle && !have_idle_q) begin
            have_idle_q <= 1'b1;
            idle_slot_q <= idx_q;
          end
        end
      end
      OP_PICK: begin
        cur_id_q       <= rd_id;
        pend_q[idx_q]  <= new_pend;
        res_status_q   <= RS_DONE;
        if (kill) begin
          exit_q[idx_q] <= '1;
          wake_pid_q    <= rd_id;
          res_killed_q  <= 1'b1;
        end
      end
      OP_WAKE: begin
        if (rd_st == SS_WAIT && rd_wpid == {1'b0, wake_pid_q}) wpid_q[idx_q] <= WAIT_NONE;
      end
      OP_CREATE: begin
        if (rd_st == SS_UNUSED) begin
          id_q[idx_q]   <= id_cnt_q;
          idle_q[idx_q] <= r_idle_q;
          grp_q[idx_q]  <= (r_grp_q != '0) ? r_grp_q : id_cnt_q;
          wpid_q[idx_q] <= WAIT_NONE;
          pend_q[idx_q] <= '0;
          blk_q[idx_q]  <= '0;
          exit_q[idx_q] <= '0;
          if (!cur_valid_q) cur_id_q <= id_cnt_q;
          if (!head_valid_q) next_q[idx_q] <= idx_q;
          new_q         <= idx_q;
          res_status_q  <= RS_DONE;
          res_slot_q    <= idx_q;
          res_tid_q     <= id_cnt_q;
        end else if (last) begin
          res_status_q <= RS_FULL;
        end
      end
      OP_INSERT: begin
        next_q[new_q] <= rd_next;
        next_q[idx_q] <= new_q;
      end
      OP_EXIT: begin
        exit_q[idx_q] <= r_exv_q;
        wake_pid_q    <= rd_id;
        res_status_q  <= RS_DONE;
      end
      OP_FIND: begin
        if (find_hit) begin
          ch_q      <= idx_q;
          ch_next_q <= rd_next;
          cnt_q     <= '0;
          if (rd_st == SS_ZOMBIE) begin
            res_code_q   <= rd_exit;
            res_status_q <= RS_DONE;
          end
        end else if (last) begin
          res_status_q <= RS_NOTFOUND;
        end
      end
      OP_REMOVE: begin
        if (rm_match) next_q[idx_q] <= ch_next_q;
        else cnt_q <= cnt_q + SLOT_W'(1);
      end
      OP_BLOCK: begin
        if (rd_run) begin
          wpid_q[idx_q] <= {1'b0, r_pid_q};
          res_status_q  <= RS_BLOCKED;
        end
      end
      OP_SIGNAL: begin
        if (rd_st != SS_UNUSED && rd_grp == r_grp_q)
          pend_q[idx_q] <= rd_pend | (SIG_W'(1) << r_sig_q);
      end
      OP_MASK: begin
        blk_q[idx_q] <= r_mask_q[SIG_W-1:0];
        res_status_q <= RS_DONE;
      end
      OP_OUT: begin
        if (req_q == REQ_TICK) begin
          out_data_q <= {res_killed_q, res_code_q,
                         cur_valid_q ? cur_id_q : ID_W'(0),
                         cur_valid_q ? cur_q : SLOT_W'(0), res_status_q};
        end else begin
          out_data_q <= {res_killed_q, res_code_q, res_tid_q, res_slot_q, res_status_q};
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* src/round_robin_task_table_scheduler_unit.sv */
// round_robin_task_table_scheduler_unit: top level of the task scheduler
// holds the configuration registers; uses rrts_pkg, rrts_ctrl, rrts_datapath
//
// usage:
//   requests enter on the s_axis channel, one beat per request; the request
//   type travels on tuser, its operands on tdata. every request gives exactly
//   one result beat on the m_axis channel.
//   configuration (enable, terminate signal, interrupt signal) is written
//   over the apb port at byte addresses 0, 4 and 8 while no request is open.
// sequencing:
//   one request at a time; the shortest request is accept, dispatch and
//   result load (e.g. exit without a current task), the longest a tick with
//   a full 16-slot ring walk followed by a 16-slot waiter wake sweep. the
//   ring walk, the slot searches and the wake sweep visit one slot per cycle
//   through a single table index.
// reset:
//   all slots unused, ring empty, no current task, id counter at one,
//   scheduler disabled, terminate signal 15, interrupt signal 2.
// stalls:
//   the result register holds a finished beat while m_axis_tready is low;
//   the next request is still taken and its result waits until the register
//   frees.
module round_robin_task_table_scheduler_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  // requests
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: idle_flag, group, exit_value, target_pid, sig_number, signal_mask
  input  logic [103:0] s_axis_tdata,
  // tuser: req_type
  input  logic [2:0]   s_axis_tuser,
  // results
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: status, slot, task_id, code_out, killed
  output logic [55:0]  m_axis_tdata,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import rrts_pkg::*;

  logic       cfg_enable_q;
  logic [4:0] cfg_term_q, cfg_intr_q;
  dp_op_e     op;
  dp_stat_t   stat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_enable_q <= 1'b0;
      cfg_term_q   <= 5'd15;
      cfg_intr_q   <= 5'd2;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        CFG_ENABLE: cfg_enable_q <= pwdata[0];
        CFG_TERM:   cfg_term_q   <= pwdata[4:0];
        CFG_INTR:   cfg_intr_q   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[3:2])
      CFG_ENABLE: prdata = {31'd0, cfg_enable_q};
      CFG_TERM:   prdata = {27'd0, cfg_term_q};
      CFG_INTR:   prdata = {27'd0, cfg_intr_q};
      default:    prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  rrts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .op_o       (op)
  );

  rrts_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .cfg_enable_i (cfg_enable_q),
    .cfg_term_i   (cfg_term_q),
    .cfg_intr_i   (cfg_intr_q),
    .in_user_i    (s_axis_tuser),
    .in_data_i    (s_axis_tdata),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_data_o   (m_axis_tdata),
    .stat_o       (stat)
  );

endmodule
